### sv/id_slot_table_dedupe_compact_assert.svh
// Assertion macros for the slot table block.
// Included by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef ID_SLOT_TABLE_DEDUPE_COMPACT_ASSERT_SVH
`define ID_SLOT_TABLE_DEDUPE_COMPACT_ASSERT_SVH

`ifndef SYNTHESIS
`define ISDC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slot table assertion failed");
`define ISDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slot table assertion failed");
`else
`define ISDC_ASSERT_IMPL(lbl, ante, cons)
`define ISDC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### sv/isdc_pkg.sv
// Shared types and constants for the slot table block.
// No dependencies.
`default_nettype none

package isdc_pkg;

  localparam int ID_W           = 32;
  localparam int KIND_W         = 2;
  localparam int SLOT_LIMIT_W   = 6;
  localparam int SLOT_IDX_W     = 5;
  localparam int ENTRY_CNT_W    = 6;
  localparam int MAX_SLOTS_DEF  = 32;
  localparam int SLOT_LIMIT_RST = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_RESOLVE,
    ST_SH_FETCH,
    ST_SH_WRITE
  } state_e;

endpackage

`default_nettype wire

### sv/id_slot_table_dedupe_compact.sv
// Operation: a request scans occupied slots one at a time (FETCH, then CMP), stopping
// at a match; an empty table goes straight to RESOLVE. A remove hit then shifts each
// later entry down one slot (SH_FETCH, SH_WRITE). The single memory read port
// and the one 32-bit comparator set this pace. busy_o drops in the done cycle, so a
// new request may be issued then. The receiver cannot stall results.
// Reset: asynchronous, active low; count cleared, slot_limit set to 32, store undefined.
`default_nettype none
`include "id_slot_table_dedupe_compact_assert.svh"

// Packed identifier table with lookup, deduplicating insert and compacting remove.
// Depends on isdc_pkg.
module id_slot_table_dedupe_compact
  import isdc_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    slot_limit_we_i,
  input  wire logic [SLOT_LIMIT_W-1:0] slot_limit_i,
  input  wire logic                    start_i,
  input  wire logic [KIND_W-1:0]       kind_i,
  input  wire logic [ID_W-1:0]         resource_id_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic                         hit_o,
  output logic [SLOT_IDX_W-1:0]        slot_index_o,
  output logic                         rejected_o,
  output logic [ENTRY_CNT_W-1:0]       entry_count_o
);

  localparam int IdxW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CntW  = $clog2(MAX_SLOTS + 1);
  localparam int CmpW  = (CntW > SLOT_LIMIT_W) ? CntW : SLOT_LIMIT_W;
  localparam int SlotW = (IdxW > SLOT_IDX_W) ? IdxW : SLOT_IDX_W;
  localparam int OutCW = (CntW > ENTRY_CNT_W) ? CntW : ENTRY_CNT_W;

  state_e                  state_q, state_d;
  logic [SLOT_LIMIT_W-1:0] limit_q;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic [IdxW-1:0]         slot_q, slot_d;
  logic                    found_q, found_d;
  logic                    rej_q, rej_d;
  logic                    done_q, done_d;
  logic [KIND_W-1:0]       kind_q;
  logic [ID_W-1:0]         key_q;

  logic [ID_W-1:0]         mem [MAX_SLOTS];
  logic [ID_W-1:0]         rd_data_q;
  logic [IdxW-1:0]         rd_addr;
  logic                    mem_we;
  logic [IdxW-1:0]         mem_waddr;
  logic [ID_W-1:0]         mem_wdata;

  logic                    accept;
  logic                    match;
  logic                    more_scan;
  logic                    more_shift;
  logic                    need_shift;
  logic                    can_insert;
  logic [CmpW-1:0]         limit_eff;
  logic [SlotW-1:0]        slot_wide;
  logic [OutCW-1:0]        cnt_wide;

  assign accept     = start_i && (state_q == ST_IDLE);
  assign match      = (rd_data_q == key_q);
  assign more_scan  = (CntW'(idx_q) + CntW'(1)) < cnt_q;
  assign need_shift = more_scan;
  assign more_shift = (CntW'(idx_q) + CntW'(2)) < cnt_q;
  assign limit_eff  = (CmpW'(limit_q) > CmpW'(MAX_SLOTS)) ? CmpW'(MAX_SLOTS)
                                                          : CmpW'(limit_q);
  assign can_insert = CmpW'(cnt_q) < limit_eff;

  // Store with separate write and read addresses: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (cnt_q == '0) ? ST_RESOLVE : ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_CMP;
      ST_CMP: begin
        if (!match && more_scan) begin
          state_d = ST_FETCH;
        end else begin
          state_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if ((kind_q == KIND_REMOVE) && found_q && need_shift) begin
          state_d = ST_SH_FETCH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SH_FETCH: state_d = ST_SH_WRITE;
      ST_SH_WRITE: state_d = more_shift ? ST_SH_FETCH : ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    idx_d     = idx_q;
    slot_d    = slot_q;
    found_d   = found_q;
    rej_d     = rej_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    rd_addr   = idx_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = rd_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          idx_d   = '0;
          slot_d  = '0;
          found_d = 1'b0;
          rej_d   = 1'b0;
        end
      end
      ST_FETCH: rd_addr = idx_q;
      ST_CMP: begin
        if (match) begin
          found_d = 1'b1;
          slot_d  = idx_q;
        end else if (more_scan) begin
          idx_d = IdxW'(CntW'(idx_q) + CntW'(1));
        end
      end
      ST_RESOLVE: begin
        priority if (kind_q == KIND_INSERT && !found_q) begin
          done_d = 1'b1;
          if (can_insert) begin
            mem_we    = 1'b1;
            mem_waddr = IdxW'(cnt_q);
            mem_wdata = key_q;
            slot_d    = IdxW'(cnt_q);
            cnt_d     = cnt_q + CntW'(1);
          end else begin
            rej_d = 1'b1;
          end
        end else if (kind_q == KIND_REMOVE && found_q) begin
          // idx_q already points at the matched slot
          if (!need_shift) begin
            cnt_d  = cnt_q - CntW'(1);
            done_d = 1'b1;
          end
        end else begin
          done_d = 1'b1;
        end
      end
      ST_SH_FETCH: rd_addr = IdxW'(CntW'(idx_q) + CntW'(1));
      ST_SH_WRITE: begin
        // move the next entry down one slot
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rd_data_q;
        if (more_shift) begin
          idx_d = IdxW'(CntW'(idx_q) + CntW'(1));
        end else begin
          cnt_d  = cnt_q - CntW'(1);
          done_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      limit_q <= SLOT_LIMIT_W'(SLOT_LIMIT_RST);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (slot_limit_we_i) begin
        limit_q <= slot_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    slot_q  <= slot_d;
    found_q <= found_d;
    rej_q   <= rej_d;
    if (accept) begin
      kind_q <= kind_i;
      key_q  <= resource_id_i;
    end
  end

  assign slot_wide     = SlotW'(slot_q);
  assign cnt_wide      = OutCW'(cnt_q);
  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign hit_o         = found_q;
  assign rejected_o    = rej_q;
  assign slot_index_o  = slot_wide[SLOT_IDX_W-1:0];
  assign entry_count_o = cnt_wide[ENTRY_CNT_W-1:0];

  `ISDC_ASSERT_IMPL(a_count_bound, 1'b1, CmpW'(cnt_q) <= CmpW'(MAX_SLOTS))
  `ISDC_ASSERT_IMPL(a_reject_clean, done_o && rejected_o, !hit_o && (slot_q == '0))
  `ISDC_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  `ISDC_ASSERT_NEXT(a_count_step, !busy_o, $stable(cnt_q) || done_o)

endmodule

`default_nettype wire
